[rtl/ipv4d_pkg.sv]
// Shared types and constants for the IPv4 stream deframer.
`default_nettype none

package ipv4d_pkg;

  localparam int HeaderBytes = 20;
  localparam int FillW       = $clog2(HeaderBytes + 1);
  localparam int QDepth      = 4;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  localparam logic [3:0]  IpVersion4 = 4'd4;
  localparam logic [15:0] MaxLenRst  = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_BODY       = 3'd0,
    CMD_BODY_LAST  = 3'd1,
    CMD_DROP       = 3'd2,
    CMD_HEAD_FIRST = 3'd3,
    CMD_HEAD_MID   = 3'd4,
    CMD_HEAD_END   = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] data;
    cmd_kind_e  kind;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/ipv4d_front.sv]
// Front end: byte intake, head window, plausibility check and item classification.
`default_nettype none

module ipv4d_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output ipv4d_pkg::cmd_t      cmd_o
);
  import ipv4d_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_BURST = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [7:0]         win_q [HeaderBytes];
  logic [FillW-1:0]   fill_q, fill_d;
  logic [FillW-1:0]   burst_q, burst_d;
  logic [15:0]        left_q, left_d;
  logic [15:0]        max_len_q;
  logic               accept;
  logic               plausible;
  logic               shift;
  logic               store;
  logic [5:0]         ihl_bytes;
  logic [15:0]        total;

  assign ihl_bytes = {win_q[0][3:0], 2'b00};
  assign total     = {win_q[2], win_q[3]};
  assign plausible = (win_q[0][7:4] == IpVersion4) &&
                     (ihl_bytes >= 6'(HeaderBytes)) &&
                     (total >= {10'd0, ihl_bytes}) &&
                     (total <= max_len_q);

  assign in_stall_o = !(state_q == ST_IDLE && !q_full_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    burst_d  = burst_q;
    left_d   = left_q;
    push_o   = 1'b0;
    shift    = 1'b0;
    store    = 1'b0;
    cmd_o    = '{data: in_byte_i, kind: CMD_BODY};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (left_q != 16'd0) begin
            push_o = 1'b1;
            cmd_o  = '{data: in_byte_i,
                       kind: (left_q == 16'd1) ? CMD_BODY_LAST : CMD_BODY};
            left_d = left_q - 16'd1;
          end else begin
            store  = 1'b1;
            fill_d = fill_q + FillW'(1);
            if (fill_q == FillW'(HeaderBytes - 1)) begin
              state_d = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (plausible) begin
          state_d = ST_BURST;
          burst_d = '0;
          left_d  = total - 16'(HeaderBytes);
        end else if (!q_full_i) begin
          push_o  = 1'b1;
          cmd_o   = '{data: win_q[0], kind: CMD_DROP};
          shift   = 1'b1;
          fill_d  = FillW'(HeaderBytes - 1);
          state_d = ST_IDLE;
        end
      end
      ST_BURST: begin
        if (!q_full_i) begin
          push_o = 1'b1;
          shift  = 1'b1;
          if (burst_q == '0) begin
            cmd_o = '{data: win_q[0], kind: CMD_HEAD_FIRST};
          end else if (burst_q == FillW'(HeaderBytes - 1) && left_q == 16'd0) begin
            cmd_o = '{data: win_q[0], kind: CMD_HEAD_END};
          end else begin
            cmd_o = '{data: win_q[0], kind: CMD_HEAD_MID};
          end
          burst_d = burst_q + FillW'(1);
          if (burst_q == FillW'(HeaderBytes - 1)) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      burst_q   <= '0;
      left_q    <= '0;
      max_len_q <= MaxLenRst;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      burst_q <= burst_d;
      left_q  <= left_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      for (int i = 0; i < HeaderBytes - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end else if (store) begin
      win_q[fill_q] <= in_byte_i;
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(HeaderBytes))
    else $error("head window fill out of range");

  a_check_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> fill_q == FillW'(HeaderBytes))
    else $error("head check without a full window");

  a_burst_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BURST && $past(state_q) != ST_BURST |-> $past(state_q) == ST_CHECK)
    else $error("burst entered without a check");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("push into a full queue");

endmodule

`default_nettype wire

[rtl/ipv4d_queue.sv]
// Small command queue between the front end and the output stage.
`default_nettype none

module ipv4d_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ipv4d_pkg::cmd_t  push_cmd_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output ipv4d_pkg::cmd_t       head_o
);
  import ipv4d_pkg::*;

  cmd_t               mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q;
  logic [QPtrW-1:0]   rd_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPtrW'(wr_q - rd_q) == QPtrW'(cnt_q))
    else $error("queue pointers disagree with count");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + QCntW'(1))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

[rtl/ipv4d_back.sv]
// Back end: decodes queued commands into result items and holds them for the receiver.
`default_nettype none

module ipv4d_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire ipv4d_pkg::cmd_t  q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  first_of_packet_o,
  output logic                  last_of_packet_o,
  output logic                  dropped_o
);
  import ipv4d_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       first_q, last_q, drop_q;
  logic       load;
  logic       first_d, last_d, drop_d;

  assign load    = !valid_q || !out_stall_i;
  assign q_pop_o = load && !q_empty_i;

  always_comb begin
    first_d = 1'b0;
    last_d  = 1'b0;
    drop_d  = 1'b0;
    unique case (q_head_i.kind)
      CMD_BODY:       ;
      CMD_BODY_LAST:  last_d  = 1'b1;
      CMD_DROP:       drop_d  = 1'b1;
      CMD_HEAD_FIRST: first_d = 1'b1;
      CMD_HEAD_MID:   ;
      CMD_HEAD_END:   last_d  = 1'b1;
      default:        ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q  <= q_head_i.data;
      first_q <= first_d;
      last_q  <= last_d;
      drop_q  <= drop_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign out_byte_o        = byte_q;
  assign first_of_packet_o = first_q;
  assign last_of_packet_o  = last_q;
  assign dropped_o         = drop_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $countones({first_q, last_q, drop_q}) <= 1)
    else $error("conflicting result flags");

  a_pop_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> valid_q)
    else $error("popped item not presented");

  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |-> !q_pop_o)
    else $error("pop while result is stalled");

endmodule

`default_nettype wire

[rtl/ipv4_stream_deframer_resync.sv]
// Top level of the IPv4 stream deframer with byte-wise resynchronization.
//
// Input channel: in_valid_i / in_stall_o / in_byte_i carries raw stream bytes.
// Output channel: out_valid_o / out_stall_i carries one byte per item with
// first_of_packet_o, last_of_packet_o and dropped_o flags.
// Configuration: cfg_we_i writes cfg_wdata_i into the maximum packet length;
// write only while no item is in flight.
// Throughput: a body byte or a head byte still filling the window is accepted
// whenever the queue has space. A complete head then enters a check state,
// which also emits the dropped byte when the head is implausible; a plausible
// head then moves on to a burst of the 20 head bytes, one result per cycle
// while the queue has space, set by the single read port of the head window.
// Input is held off during check and burst. A body byte is queued, then registered.
// Reset: the window empties, no packet is open and the maximum length
// returns to 65535. When the receiver stalls, the output register holds its
// item, the four-entry queue fills and then the input is stalled.
`default_nettype none

module ipv4_stream_deframer_resync (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             first_of_packet_o,
  output logic             last_of_packet_o,
  output logic             dropped_o
);
  import ipv4d_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_head;

  ipv4d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  ipv4d_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  ipv4d_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_head_i          (q_head),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .first_of_packet_o (first_of_packet_o),
    .last_of_packet_o  (last_of_packet_o),
    .dropped_o         (dropped_o)
  );

endmodule

`default_nettype wire

[tb/ipv4_stream_deframer_resync_tb.sv]
// Self-checking testbench for the IPv4 stream deframer: random packet streams against a predictor.
module ipv4_stream_deframer_resync_tb;
  import ipv4d_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
    logic       is_drop;
  } beat_t;

  class deframe_scoreboard;
    logic [7:0]  win [HeaderBytes];
    int unsigned fill;
    logic [15:0] remaining;
    logic [15:0] max_len;
    beat_t       cut_q [$];
    int unsigned errors;

    function new();
      fill      = 0;
      remaining = '0;
      max_len   = MaxLenRst;
      errors    = 0;
    endfunction

    function void set_max_len(logic [15:0] v);
      max_len = v;
    endfunction

    // Predict the items that one accepted stream byte releases.
    function void absorb_byte(logic [7:0] b);
      logic [3:0]  ver;
      logic [5:0]  ihl_bytes;
      logic [15:0] total;
      beat_t       r;
      if (remaining != 0) begin
        r = '{data: b, is_first: 1'b0, is_last: (remaining == 16'd1), is_drop: 1'b0};
        cut_q.push_back(r);
        remaining = remaining - 16'd1;
        return;
      end
      if (fill >= HeaderBytes) fill = HeaderBytes - 1;
      win[fill] = b;
      fill++;
      if (fill < HeaderBytes) return;
      ver       = win[0][7:4];
      ihl_bytes = {win[0][3:0], 2'b00};
      total     = {win[2], win[3]};
      if (ver == IpVersion4 && ihl_bytes >= HeaderBytes && total >= ihl_bytes &&
          total <= max_len) begin
        for (int k = 0; k < HeaderBytes; k++) begin
          r = '{data: win[k], is_first: (k == 0),
                is_last: (k == HeaderBytes - 1 && total == HeaderBytes), is_drop: 1'b0};
          cut_q.push_back(r);
        end
        remaining = total - 16'(HeaderBytes);
        fill      = 0;
      end else begin
        r = '{data: win[0], is_first: 1'b0, is_last: 1'b0, is_drop: 1'b1};
        cut_q.push_back(r);
        for (int k = 0; k < HeaderBytes - 1; k++) win[k] = win[k + 1];
        fill = HeaderBytes - 1;
      end
    endfunction

    function void field_ok(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void compare_beat(logic [7:0] d, logic f, logic l, logic x);
      beat_t want;
      if (cut_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item expected none actual byte %0h first %0b last %0b drop %0b",
                 $time, d, f, l, x);
        return;
      end
      want = cut_q.pop_front();
      field_ok("out_byte", want.data, d);
      field_ok("first_of_packet", {7'd0, want.is_first}, {7'd0, f});
      field_ok("last_of_packet", {7'd0, want.is_last}, {7'd0, l});
      field_ok("dropped", {7'd0, want.is_drop}, {7'd0, x});
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        first_of_packet_o;
  logic        last_of_packet_o;
  logic        dropped_o;

  deframe_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int sent_bytes;

  ipv4_stream_deframer_resync DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_byte_i         (in_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .first_of_packet_o (first_of_packet_o),
    .last_of_packet_o  (last_of_packet_o),
    .dropped_o         (dropped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.compare_beat(out_byte_o, first_of_packet_o, last_of_packet_o, dropped_o);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 10 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    sb.absorb_byte(b);
    sent_bytes++;
  endtask

  task automatic idle_in();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (sb.cut_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_max_len(v);
  endtask

  function automatic logic [7:0] filler();
    logic [7:0] b;
    do b = 8'($urandom); while (b[7:4] == IpVersion4);
    return b;
  endfunction

  task automatic send_packet(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] total, input bit with_body);
    logic [7:0] hdr [HeaderBytes];
    for (int i = 0; i < HeaderBytes; i++) hdr[i] = filler();
    hdr[0] = {ver, ihl};
    hdr[2] = total[15:8];
    hdr[3] = total[7:0];
    for (int i = 0; i < HeaderBytes; i++) send_byte(hdr[i]);
    if (with_body) begin
      for (int i = HeaderBytes; i < int'(total); i++) send_byte(8'($urandom));
    end
  endtask

  task automatic send_good();
    int ihl;
    int lo;
    int hi;
    int cap;
    ihl = $urandom_range(15, 5);
    cap = int'(sb.max_len);
    if (cap < ihl * 4 && $urandom_range(3) != 0) ihl = 5;
    lo = ihl * 4;
    hi = lo + (($urandom_range(19) == 0) ? 580 : 40);
    if (hi > cap) hi = cap;
    if (hi < lo) hi = lo + 40;
    send_packet(IpVersion4, 4'(ihl), 16'($urandom_range(hi, lo)), 1'b1);
  endtask

  task automatic send_broken();
    logic [3:0] ver;
    int ihl;
    int total;
    int cap;
    ver   = IpVersion4;
    ihl   = $urandom_range(15, 5);
    total = $urandom_range(ihl * 4 + 40, ihl * 4);
    cap   = int'(sb.max_len);
    case ($urandom_range(3))
      0: begin
        do ver = 4'($urandom_range(15)); while (ver == IpVersion4);
      end
      1: ihl = $urandom_range(4);
      2: total = $urandom_range(ihl * 4 - 1);
      default: begin
        if (cap < 65535) total = $urandom_range(65535, cap + 1);
        else ihl = $urandom_range(4);
      end
    endcase
    send_packet(ver, 4'(ihl), 16'(total), 1'b0);
  endtask

  task automatic run_random(input int n_bytes, input int mix_pct);
    int start;
    bit paused;
    start  = sent_bytes;
    paused = 1'b0;
    while (sent_bytes - start < n_bytes) begin
      if ($urandom_range(99) >= mix_pct) begin
        send_good();
      end else if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end else begin
        send_broken();
      end
      if (!paused && sent_bytes - start >= n_bytes / 2) begin
        idle_in();
        drain();
        paused = 1'b1;
      end
    end
    idle_in();
    drain();
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    sent_bytes    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_byte_i     = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // header-only packet with extreme filler bytes
    for (int i = 0; i < HeaderBytes; i++) begin
      send_byte(i == 0 ? 8'h45 : i == 3 ? 8'h14 : i < 3 ? 8'h00 :
                (i % 2 != 0) ? 8'hFF : 8'h00);
    end
    idle_in();
    drain();

    write_max_len(MaxLenRst);
    run_random(90, 0);

    write_max_len(16'd20);
    send_idle_pct = 58;
    run_random(80, 25);

    write_max_len(16'($urandom_range(120, 40)));
    send_idle_pct = 0;
    stall_pct     = 58;
    run_random(100, 30);

    write_max_len(16'd19);
    send_idle_pct = 33;
    stall_pct     = 33;
    run_random(60, 30);

    write_max_len(16'($urandom_range(1500, 21)));
    run_random(100, 30);

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ipv4d_pkg.sv
rtl/ipv4d_front.sv
rtl/ipv4d_queue.sv
rtl/ipv4d_back.sv
rtl/ipv4_stream_deframer_resync.sv
tb/ipv4_stream_deframer_resync_tb.sv
